/* design/sha256_pkg.sv */
// Shared constants, tables and types of the SHA-256 stream hasher.
package sha256_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int HASH_WORDS  = 8;
  localparam int ROUNDS      = 64;

  // Round constants
  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial hash values
  localparam logic [31:0] INIT_H [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_BLOCK,
    ST_PAD,
    ST_PAD_BLOCK,
    ST_EMIT_READ,
    ST_EMIT_LOAD
  } ctl_state_t;

  // Compression sequencer phases
  typedef enum logic [1:0] {
    CP_IDLE,
    CP_LOAD,
    CP_ROUND,
    CP_FINAL
  } cmp_phase_t;

  // Hash memory access
  typedef struct packed {
    logic        rd_en;
    logic [2:0]  rd_addr;
    logic        wr_en;
    logic [2:0]  wr_addr;
    logic [31:0] wr_data;
  } hram_req_t;

endpackage

/* design/sha256_block_buf.sv */
// Message block buffer: packs bytes big-endian into a 16-word memory.
module sha256_block_buf import sha256_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [7:0]  wr_byte,
  input  logic [5:0]  wr_pos,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rdata
);

  logic [23:0] pack;
  logic [31:0] mem [BLOCK_WORDS];

  // Byte packing, word written on the fourth byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pack <= {pack[15:0], wr_byte};
      if (&wr_pos[1:0]) begin
        mem[wr_pos[5:2]] <= {pack, wr_byte};
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

/* design/sha256_hash_ram.sv */
// Hash value memory with per-entry valid bits; invalid entries read as the IV.
module sha256_hash_ram import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  hram_req_t   req,
  output logic [31:0] rdata
);

  logic [31:0]           mem [HASH_WORDS];
  logic [HASH_WORDS-1:0] valid;
  logic [31:0]           mem_q;
  logic                  valid_q;
  logic [2:0]            addr_q;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Valid bits: cleared at reset and at end of message
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q   <= mem[req.rd_addr];
      valid_q <= valid[req.rd_addr];
      addr_q  <= req.rd_addr;
    end
  end

  assign rdata = valid_q ? mem_q : INIT_H[addr_q];

  // Read-modify-write never reads the entry being written
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (req.rd_en && req.wr_en) |-> (req.rd_addr != req.wr_addr))
    else $error("hash memory read and write hit the same entry");

endmodule

/* design/sha256_compress.sv */
// Compression sequencer: load hash, 64 rounds with rolling schedule, add back.
module sha256_compress import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  output hram_req_t   hram_req,
  input  logic [31:0] hram_rdata,
  output logic        buf_rd_en,
  output logic [3:0]  buf_rd_addr,
  input  logic [31:0] buf_rdata
);

  localparam logic [6:0] XFER_LAST  = 7'(HASH_WORDS);
  localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
  localparam logic [6:0] BUF_ROUNDS = 7'(BLOCK_WORDS);

  cmp_phase_t  phase, phase_next;
  logic [6:0]  cnt, cnt_next;
  logic [31:0] wv [HASH_WORDS];
  logic [31:0] sched [BLOCK_WORDS];
  logic [31:0] w_q;
  logic [31:0] w_cur, w_next, t1, t2;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // Round datapath; w for rounds 16+ is computed one round ahead
  assign w_cur  = (cnt < BUF_ROUNDS) ? buf_rdata : w_q;
  assign t1     = wv[7] + bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
                + ROUND_K[cnt[5:0]] + w_cur;
  assign t2     = bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  assign w_next = sched[1] + ssig0(sched[2]) + sched[10] + ssig1(sched[15]);

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= CP_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  // Next phase and memory ports
  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt + 7'd1;
    hram_req    = '0;
    buf_rd_en   = 1'b0;
    buf_rd_addr = '0;
    done        = 1'b0;
    unique case (phase)
      CP_IDLE: begin
        cnt_next = '0;
        if (start) begin
          phase_next = CP_LOAD;
        end
      end
      CP_LOAD: begin
        hram_req.rd_en   = (cnt < XFER_LAST);
        hram_req.rd_addr = cnt[2:0];
        if (cnt == XFER_LAST) begin
          buf_rd_en  = 1'b1;
          phase_next = CP_ROUND;
          cnt_next   = '0;
        end
      end
      CP_ROUND: begin
        buf_rd_en   = (cnt < BUF_ROUNDS - 7'd1);
        buf_rd_addr = cnt[3:0] + 4'd1;
        if (cnt == ROUND_LAST) begin
          phase_next = CP_FINAL;
          cnt_next   = '0;
        end
      end
      CP_FINAL: begin
        hram_req.rd_en   = (cnt < XFER_LAST);
        hram_req.rd_addr = cnt[2:0];
        hram_req.wr_en   = (cnt != '0);
        hram_req.wr_addr = cnt[2:0] - 3'd1;
        hram_req.wr_data = hram_rdata + wv[0];
        if (cnt == XFER_LAST) begin
          done       = 1'b1;
          phase_next = CP_IDLE;
          cnt_next   = '0;
        end
      end
      default: begin
        phase_next = CP_IDLE;
      end
    endcase
  end

  assign busy = (phase != CP_IDLE);

  // Working variables and schedule shift line
  always_ff @(posedge clk) begin
    case (phase) inside
      CP_LOAD, CP_FINAL: begin
        if (cnt != '0) begin
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            wv[i] <= wv[i+1];
          end
          wv[HASH_WORDS-1] <= hram_rdata;
        end
      end
      CP_ROUND: begin
        wv[0] <= t1 + t2;
        wv[1] <= wv[0];
        wv[2] <= wv[1];
        wv[3] <= wv[2];
        wv[4] <= wv[3] + t1;
        wv[5] <= wv[4];
        wv[6] <= wv[5];
        wv[7] <= wv[6];
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          sched[i] <= sched[i+1];
        end
        sched[BLOCK_WORDS-1] <= w_cur;
        w_q <= w_next;
      end
      default: begin
      end
    endcase
  end

  // A new block only starts on an idle sequencer
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (phase == CP_IDLE))
    else $error("compression started while busy");

endmodule

/* design/sha256_stream_hasher_core.sv */
// Top level of the SHA-256 stream hasher: control, length count, padding, digest output.
//
// Input stream (s_*): one message byte per word. s_tdata[7:0] is the byte,
// s_tuser says the byte is present, s_tlast ends the message after it.
// Output stream (m_*): eight digest words per message, H0 first;
// m_tuser is the word index, m_tlast marks the eighth word.
// Bytes are taken one per cycle while a block fills. When the 64th byte of
// a block arrives, s_tready drops while the block is compressed: the hash
// memory is loaded, the rounds read the block memory, and the results are
// added back into the hash memory. On end of message the padding bytes are
// written one per cycle up to the block end (one or two padded blocks, each
// then compressed), and the digest follows, each word read from the hash memory.
// If the message grows past 2^61-1 bytes, further bytes are dropped and the
// digest reads as zeros. After the eighth word is loaded the block is back
// at the initial hash values and takes the next message, even while that
// word still waits. A stalled receiver holds the current word and pauses
// the digest readout. Reset clears all control state and restores the
// initial hash values at once; no clearing pass is needed.
module sha256_stream_hasher_core import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast
);

  localparam int         LEN_W     = 61;
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  ctl_state_t       state, state_next;
  logic [5:0]       fill;
  logic [LEN_W-1:0] msg_bytes;
  logic             overflow, marker, ext, final_blk, end_pend;
  logic [2:0]       emit_idx;

  logic             take, len_full, ovf_hit, ovf_now, absorb_wr, buf_wr, cmp_start;
  logic             pad_len, emit_go, finish;
  logic [63:0]      len_bits;
  logic [7:0]       len_byte, pad_byte, buf_data;

  logic             cmp_busy, cmp_done;
  hram_req_t        cmp_req, emit_req, hram_req;
  logic [31:0]      hram_rdata;
  logic             buf_rd_en;
  logic [3:0]       buf_rd_addr;
  logic [31:0]      buf_rdata;

  // Input decode and padding byte
  assign take      = s_tvalid && s_tready;
  assign len_full  = &msg_bytes;
  assign ovf_hit   = take && s_tuser && len_full;
  assign ovf_now   = overflow || ovf_hit;
  assign absorb_wr = take && s_tuser && !len_full;
  assign len_bits  = {msg_bytes, 3'b000};
  assign len_byte  = len_bits[{~fill[2:0], 3'b000} +: 8];
  assign pad_len   = marker && !ext && (fill >= LEN_START);
  assign pad_byte  = !marker ? PAD_MARK : (pad_len ? len_byte : 8'h00);
  assign buf_wr    = absorb_wr || (state == ST_PAD);
  assign buf_data  = (state == ST_PAD) ? pad_byte : s_tdata;
  assign cmp_start = buf_wr && (&fill);
  assign emit_go   = (state == ST_EMIT_READ) && (!m_tvalid || m_tready);
  assign finish    = (state == ST_EMIT_LOAD) && (&emit_idx);
  assign s_tready  = (state == ST_ABSORB);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ABSORB;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ABSORB: begin
        if (take) begin
          if (cmp_start) begin
            state_next = ST_BLOCK;
          end else if (s_tlast) begin
            state_next = ovf_now ? ST_EMIT_READ : ST_PAD;
          end
        end
      end
      ST_BLOCK: begin
        if (cmp_done) begin
          if (!end_pend) begin
            state_next = ST_ABSORB;
          end else begin
            state_next = overflow ? ST_EMIT_READ : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (&fill) begin
          state_next = ST_PAD_BLOCK;
        end
      end
      ST_PAD_BLOCK: begin
        if (cmp_done) begin
          state_next = final_blk ? ST_EMIT_READ : ST_PAD;
        end
      end
      ST_EMIT_READ: begin
        if (emit_go) begin
          state_next = ST_EMIT_LOAD;
        end
      end
      ST_EMIT_LOAD: begin
        state_next = (&emit_idx) ? ST_ABSORB : ST_EMIT_READ;
      end
      default: begin
        state_next = ST_ABSORB;
      end
    endcase
  end

  // Message counters and padding flags
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      fill      <= '0;
      msg_bytes <= '0;
      overflow  <= 1'b0;
      marker    <= 1'b0;
      ext       <= 1'b0;
      final_blk <= 1'b0;
      end_pend  <= 1'b0;
      emit_idx  <= '0;
    end else begin
      if (buf_wr) begin
        fill <= fill + 6'd1;
      end
      if (absorb_wr) begin
        msg_bytes <= msg_bytes + LEN_W'(1);
      end
      if (ovf_hit) begin
        overflow <= 1'b1;
      end
      if (take) begin
        end_pend <= s_tlast;
      end
      // marker placed in the length field pushes the length to a new block
      if (state == ST_PAD) begin
        if (&fill) begin
          final_blk <= marker && !ext;
          ext       <= 1'b0;
        end else if (!marker) begin
          ext <= (fill >= LEN_START);
        end
        marker <= 1'b1;
      end
      if (state == ST_EMIT_LOAD) begin
        emit_idx <= emit_idx + 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT_LOAD) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LOAD) begin
      m_tdata <= overflow ? 32'h0 : hram_rdata;
      m_tuser <= emit_idx;
      m_tlast <= &emit_idx;
    end
  end

  // Hash memory port: sequencer while compressing, digest readout otherwise
  always_comb begin
    emit_req         = '0;
    emit_req.rd_en   = emit_go;
    emit_req.rd_addr = emit_idx;
  end

  assign hram_req = cmp_busy ? cmp_req : emit_req;

  sha256_block_buf u_block_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_byte (buf_data),
    .wr_pos  (fill),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rdata   (buf_rdata)
  );

  sha256_hash_ram u_hash_ram (
    .clk   (clk),
    .rst   (rst),
    .clear (finish),
    .req   (hram_req),
    .rdata (hram_rdata)
  );

  sha256_compress u_compress (
    .clk         (clk),
    .rst         (rst),
    .start       (cmp_start),
    .busy        (cmp_busy),
    .done        (cmp_done),
    .hram_req    (cmp_req),
    .hram_rdata  (hram_rdata),
    .buf_rd_en   (buf_rd_en),
    .buf_rd_addr (buf_rd_addr),
    .buf_rdata   (buf_rdata)
  );

  // No byte is taken while a block is being compressed
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmp_busy |-> !s_tready)
    else $error("input accepted during compression");

  // Output word appears only from the digest readout
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EMIT_LOAD))
    else $error("output word without digest readout");

  // A compression always starts on a full block
  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    cmp_start |=> (fill == '0))
    else $error("block fill did not wrap at compression start");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the SHA-256 stream hasher core.
module tb_top import sha256_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          BLOCK_BYTES    = 64;
  localparam int          LEN_FIELD_POS  = 56;
  localparam logic [7:0]  PAD_MARK       = 8'h80;
  localparam logic [63:0] BYTE_LIMIT     = 64'h1FFF_FFFF_FFFF_FFFF;
  // Message lengths around the padding and block boundaries
  localparam int          EDGE_LENGTHS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic        s_tuser = 1'b0; // [0] has_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;        // [31:0] digest_word
  logic [2:0]  m_tuser;        // [2:0] word_index
  logic        m_tlast;

  // Predicted hasher state
  logic [31:0] hash_state [HASH_WORDS];
  logic [7:0]  blk_buf [BLOCK_BYTES];
  int          blk_fill;
  logic [63:0] msg_len;
  bit          len_overflow;

  digest_out_t digest_queue [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_left = 0;

  sha256_stream_hasher_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void restart_hash();
    hash_state   = INIT_H;
    blk_fill     = 0;
    msg_len      = '0;
    len_overflow = 1'b0;
  endfunction

  // One 64-round compression of the held block into hash_state
  function automatic void compress_held_block();
    logic [31:0] sched [ROUNDS];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2, s0, s1;
    int i;
    for (i = 0; i < BLOCK_WORDS; i++)
      sched[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (i = BLOCK_WORDS; i < ROUNDS; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    va = hash_state[0]; vb = hash_state[1]; vc = hash_state[2]; vd = hash_state[3];
    ve = hash_state[4]; vf = hash_state[5]; vg = hash_state[6]; vh = hash_state[7];
    for (i = 0; i < ROUNDS; i++) begin
      t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg)) +
           ROUND_K[i] + sched[i];
      t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    hash_state[0] += va; hash_state[1] += vb; hash_state[2] += vc; hash_state[3] += vd;
    hash_state[4] += ve; hash_state[5] += vf; hash_state[6] += vg; hash_state[7] += vh;
  endfunction

  // Absorb one accepted input word; queue the digest on end of message
  function automatic void absorb_word(input logic [7:0] data_byte, input logic has_byte,
                                      input logic end_of_message);
    logic [63:0] bit_len;
    int n, i;
    if (has_byte) begin
      if (msg_len >= BYTE_LIMIT) begin
        len_overflow = 1'b1;
      end else begin
        msg_len++;
        blk_buf[blk_fill] = data_byte;
        blk_fill++;
        if (blk_fill == BLOCK_BYTES) begin
          compress_held_block();
          blk_fill = 0;
        end
      end
    end
    if (!end_of_message)
      return;
    if (!len_overflow) begin
      bit_len = msg_len << 3;
      n = blk_fill;
      blk_buf[n] = PAD_MARK;
      n++;
      // no room for the length field: pad out and spend an extra block
      if (n > LEN_FIELD_POS) begin
        while (n < BLOCK_BYTES) begin
          blk_buf[n] = 8'h00;
          n++;
        end
        compress_held_block();
        n = 0;
      end
      while (n < LEN_FIELD_POS) begin
        blk_buf[n] = 8'h00;
        n++;
      end
      for (i = 0; i < 8; i++)
        blk_buf[BLOCK_BYTES-1-i] = bit_len[8*i +: 8];
      compress_held_block();
    end
    for (i = 0; i < HASH_WORDS; i++)
      digest_queue.push_back('{digest_word: len_overflow ? 32'h0 : hash_state[i],
                               word_index: 3'(i), last_word: (i == HASH_WORDS - 1)});
    restart_hash();
  endfunction

  // Monitor: prediction on input accept, check on output accept, watchdog
  always @(posedge clk) begin
    digest_out_t exp_word;
    if (rst) begin
      restart_hash();
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (digest_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest word %h index %0d last %b", m_tdata, m_tuser, m_tlast);
        end else begin
          exp_word = digest_queue.pop_front();
          if (m_tdata !== exp_word.digest_word || m_tuser !== exp_word.word_index ||
              m_tlast !== exp_word.last_word) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       exp_word.digest_word, exp_word.word_index, exp_word.last_word,
                       m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready)
        absorb_word(s_tdata, s_tuser, s_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus an optional long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        m_tready = 1'b0;
        rx_hold_left--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one input word, with random idle cycles first; returns at a falling edge
  task automatic send_word(input logic [7:0] data_byte, input logic has_byte,
                           input logic end_of_message);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = data_byte;
    s_tuser  = has_byte;
    s_tlast  = end_of_message;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Empty message, short known messages, extreme bytes, ignored words
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h7F, 1'b1, 1'b1);
    s_tvalid = 1'b0;
  endtask

  // Random messages: mostly short, some on block boundaries, a few long
  task automatic test_random_messages(input int word_budget, input int idle_pct,
                                      input int stall_pct);
    int sent, len, pick, k;
    bit sep_end;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    sent = 0;
    while (sent < word_budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        len = $urandom_range(0, 24);
      else if (pick < 9)
        len = EDGE_LENGTHS[$urandom_range(0, 8)];
      else
        len = $urandom_range(25, 200);
      sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
      for (k = 0; k < len; k++) begin
        // occasional empty word that the block must ignore
        if ($urandom_range(0, 9) == 0)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1, !sep_end && (k == len - 1));
      end
      if (sep_end)
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      sent += len + int'(sep_end);
    end
    s_tvalid = 1'b0;
  endtask

  // Receiver holds off long enough that the core backs up into its input
  task automatic test_backpressure();
    int m;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    rx_hold_left = 400;
    @(negedge clk);
    for (m = 0; m < 5; m++) begin
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
    s_tvalid = 1'b0;
  endtask

  initial begin
    restart_hash();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_messages(50, 0, 0);
    test_random_messages(50, 63, 0);
    test_random_messages(50, 0, 63);
    test_random_messages(50, 6, 6);
    test_backpressure();
    // drain outstanding digests, then let the pipeline settle
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sha256_pkg.sv
design/sha256_block_buf.sv
design/sha256_hash_ram.sv
design/sha256_compress.sv
design/sha256_stream_hasher_core.sv
sim/tb_top.sv
